[src/npr_pkg.sv]
`default_nettype none
package npr_pkg;

    // polynomial size, a power of two
    localparam int POLY_SIZE  = 1024;
    localparam int ADDR_W     = $clog2(POLY_SIZE);
    localparam int EXP_W      = ADDR_W + 1;
    localparam int INDEX_W    = 10;
    localparam int EXPO_W     = 11;
    localparam int COEF_W     = 32;

    // stream packing
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 1;

    localparam int IDX_LSB    = 0;
    localparam int EXPO_LSB   = IDX_LSB + INDEX_W;
    localparam int VAL_LSB    = EXPO_LSB + EXPO_W;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_MUL_XA    = 2'd1,
        CMD_MUL_XA_M1 = 2'd2,
        CMD_EXTRACT   = 2'd3
    } cmd_t;

    // read operation control carried alongside the memory read
    typedef struct packed {
        logic negate;
        logic sub_self;
        logic zero;
        logic status;
    } op_ctrl_t;

endpackage
`default_nettype wire

[src/npr_ram.sv]
`default_nettype none
module npr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

[src/npr_addr_gen.sv]
`default_nettype none
module npr_addr_gen (
    input  wire npr_pkg::cmd_t                  cmd,
    input  wire logic [npr_pkg::INDEX_W-1:0]    coef_index,
    input  wire logic [npr_pkg::EXPO_W-1:0]     exponent,
    output logic      [npr_pkg::ADDR_W-1:0]     addr_a,
    output logic      [npr_pkg::ADDR_W-1:0]     addr_b,
    output logic                                pos_ok,
    output npr_pkg::op_ctrl_t                   ctrl
);

    localparam int EXT_W = (npr_pkg::EXPO_W > npr_pkg::INDEX_W) ?
                           npr_pkg::EXPO_W + 1 : npr_pkg::INDEX_W + 1;

    logic [EXT_W-1:0]           pos_ext;
    logic [EXT_W-1:0]           expo_ext;
    logic [npr_pkg::EXP_W-1:0]  rot_a;
    logic [npr_pkg::EXP_W-1:0]  rot_t;
    logic [npr_pkg::ADDR_W-1:0] ext_t;
    logic                       expo_ok;

    assign pos_ext  = EXT_W'(coef_index);
    assign expo_ext = EXT_W'(exponent);
    assign pos_ok   = pos_ext < EXT_W'(npr_pkg::POLY_SIZE);
    assign expo_ok  = expo_ext < EXT_W'(npr_pkg::POLY_SIZE);

    // rotation: exponent modulo 2N, source index (i - a) modulo 2N
    assign rot_a = npr_pkg::EXP_W'(exponent);
    assign rot_t = npr_pkg::EXP_W'(coef_index) - rot_a;

    // extraction: source index (idx - i) modulo N, negated when i > idx
    assign ext_t = npr_pkg::ADDR_W'(exponent) - npr_pkg::ADDR_W'(coef_index);

    assign addr_b = npr_pkg::ADDR_W'(coef_index);

    always_comb begin
        addr_a        = rot_t[npr_pkg::ADDR_W-1:0];
        ctrl.negate   = rot_t[npr_pkg::EXP_W-1];
        ctrl.sub_self = 1'b0;
        ctrl.zero     = !pos_ok;
        ctrl.status   = 1'b0;
        unique case (cmd)
            npr_pkg::CMD_MUL_XA_M1: begin
                ctrl.sub_self = 1'b1;
            end
            npr_pkg::CMD_EXTRACT: begin
                addr_a      = ext_t;
                ctrl.negate = pos_ext > expo_ext;
                ctrl.zero   = !expo_ok || !pos_ok;
                ctrl.status = !expo_ok;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[src/npr_combine.sv]
`default_nettype none
module npr_combine (
    input  wire npr_pkg::op_ctrl_t              ctrl,
    input  wire logic [npr_pkg::COEF_W-1:0]     rd_rot,
    input  wire logic [npr_pkg::COEF_W-1:0]     rd_self,
    output logic      [npr_pkg::COEF_W-1:0]     result_value
);

    logic [npr_pkg::COEF_W-1:0] signed_rot;
    logic [npr_pkg::COEF_W-1:0] diff;

    // conditional negation, then optional subtraction of the own coefficient
    assign signed_rot = ctrl.negate ? (npr_pkg::COEF_W'(0) - rd_rot) : rd_rot;
    assign diff       = ctrl.sub_self ? (signed_rot - rd_self) : signed_rot;

    assign result_value = ctrl.zero ? npr_pkg::COEF_W'(0) : diff;

endmodule
`default_nettype wire

[src/negacyclic_poly_rotate.sv]
`default_nettype none
// Negacyclic rotation unit for one polynomial modulo X^N + 1, N = 1024.
// Input stream (s_): tuser carries the command, tdata the coefficient
// position, exponent and write value. A write with an in-range position
// stores one coefficient and gives no result transaction. The three read
// commands each give one result transaction on the output stream (m_): the
// coefficient of X^a times the polynomial, of (X^a - 1) times it, or of the
// extraction reversal; tuser flags an extraction index out of range.
// A read passes through the input register, then the registered dual-port
// memory read, then the result register, which drives m_tvalid.
// Throughput is one transaction per cycle while the receiver accepts results,
// set by the two read ports of the coefficient memory which serve the
// rotated and the own coefficient in the same cycle.
// Reset clears all valid flags; the memory contents are undefined until
// each entry is written, and reading an unwritten entry gives arbitrary data.
// When the receiver stalls the pipeline holds its results in place and keeps
// accepting transactions while an empty stage remains; writes still complete
// as long as the input register can drain.
module negacyclic_poly_rotate (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [9:0] coef_index, [20:10] exponent, [52:21] coef_value, [55:53] zero
    input  wire logic [npr_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] command
    input  wire logic [npr_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] result_value
    output logic      [npr_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] status
    output logic      [npr_pkg::M_TUSER_W-1:0]     m_tuser
);

    // input stage
    logic                            v1_reg;
    npr_pkg::cmd_t                   cmd1_reg;
    logic [npr_pkg::INDEX_W-1:0]     idx1_reg;
    logic [npr_pkg::EXPO_W-1:0]      expo1_reg;
    logic [npr_pkg::COEF_W-1:0]      val1_reg;

    // memory read stage
    logic                            v2_reg;
    npr_pkg::op_ctrl_t               ctrl2_reg;

    // result stage
    logic                            m_valid_reg;
    logic [npr_pkg::COEF_W-1:0]      m_data_reg;
    logic                            m_status_reg;

    logic                            adv3;
    logic                            ld2;
    logic                            ld1;
    logic                            is_write;
    logic                            ram_we;
    logic                            v2_next;
    logic [npr_pkg::ADDR_W-1:0]      addr_a;
    logic [npr_pkg::ADDR_W-1:0]      addr_b;
    logic                            pos_ok;
    npr_pkg::op_ctrl_t               ctrl1;
    logic [npr_pkg::COEF_W-1:0]      rd_a;
    logic [npr_pkg::COEF_W-1:0]      rd_b;
    logic [npr_pkg::COEF_W-1:0]      result_next;

    // stage hand-off: each stage loads when it is empty or drains; the input stage also loads when it holds a write
    assign adv3     = !m_valid_reg || m_tready;
    assign ld2      = !v2_reg || adv3;
    assign is_write = cmd1_reg == npr_pkg::CMD_WRITE;
    assign ld1      = !v1_reg || is_write || ld2;
    assign s_tready = ld1;
    assign ram_we   = v1_reg && is_write && pos_ok;
    assign v2_next  = v1_reg && !is_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= s_tvalid;
            end
            if (ld2) begin
                v2_reg <= v2_next;
            end
            if (adv3) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ld1 && s_tvalid) begin
            cmd1_reg  <= npr_pkg::cmd_t'(s_tuser[1:0]);
            idx1_reg  <= s_tdata[npr_pkg::IDX_LSB +: npr_pkg::INDEX_W];
            expo1_reg <= s_tdata[npr_pkg::EXPO_LSB +: npr_pkg::EXPO_W];
            val1_reg  <= s_tdata[npr_pkg::VAL_LSB +: npr_pkg::COEF_W];
        end
        if (ld2) begin
            ctrl2_reg <= ctrl1;
        end
        if (adv3) begin
            m_data_reg   <= result_next;
            m_status_reg <= ctrl2_reg.status;
        end
    end

    npr_addr_gen u_addr_gen (
        .cmd        (cmd1_reg),
        .coef_index (idx1_reg),
        .exponent   (expo1_reg),
        .addr_a     (addr_a),
        .addr_b     (addr_b),
        .pos_ok     (pos_ok),
        .ctrl       (ctrl1)
    );

    npr_ram #(
        .WIDTH (npr_pkg::COEF_W),
        .DEPTH (npr_pkg::POLY_SIZE)
    ) u_coef_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (addr_b),
        .wdata   (val1_reg),
        .re      (ld2),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    npr_combine u_combine (
        .ctrl         (ctrl2_reg),
        .rd_rot       (rd_a),
        .rd_self      (rd_b),
        .result_value (result_next)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule
`default_nettype wire
